// ===== src/krs_pkg.sv =====
// Shared types and constants for the kd-tree radius search block.
`timescale 1ns / 1ps
`default_nettype none
package krs_pkg;

    localparam int MAX_NODES   = 4096;
    localparam int MAX_HITS    = 64;
    localparam int COORD_BITS  = 24;
    localparam int STACK_DEPTH = 24;
    localparam int CFG_WIDTH   = 48;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FACING     = 2'd2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] PH_DESCEND = 2'd0;
    localparam logic [1:0] PH_FAR     = 2'd1;
    localparam logic [1:0] PH_SELF    = 2'd2;

    localparam logic signed [32:0] FACING_RESET = 33'sd759135470;

    typedef struct packed {
        logic                         func;
        logic [11:0]                  node_index;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic signed [15:0]           nrm_x;
        logic signed [15:0]           nrm_y;
        logic signed [15:0]           nrm_z;
        logic [1:0]                   split_axis;
    } in_t;

    typedef struct packed {
        logic [11:0] hit_index;
        logic        hit_valid;
        logic        last;
        logic        truncated;
    } out_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic signed [COORD_BITS-1:0] pz;
        logic signed [15:0]           nx;
        logic signed [15:0]           ny;
        logic signed [15:0]           nz;
        logic [1:0]                   plane;
    } node_t;

    typedef struct packed {
        logic in_radius;
        logic facing;
        logic plane_in;
        logic plane_gt;
    } eval_t;

endpackage
`default_nettype wire

// ===== src/kd_tree_radius_search_top.sv =====
// Top level: node store, walk stack and traversal sequencer.
//
//  Channel | Direction | Handshake          | Payload
//  s_      | in        | s_valid / s_ready  | krs_pkg::in_t  (node write or query)
//  m_      | out       | m_valid / m_ready  | krs_pkg::out_t (one hit per transaction)
//  cfg_    | in        | cfg_we             | cfg_index, cfg_data
//
// Each node visit of a query passes through a RAM read, a difference stage,
// a square stage and a decision; an interior node is visited up to three
// times. Reset is synchronous and clears control state only; node storage
// is not cleared. A stalled result channel holds the walk at its next hit.
`timescale 1ns / 1ps
`default_nettype none
module kd_tree_radius_search_top #(
    parameter int MAX_NODES = krs_pkg::MAX_NODES,
    parameter int MAX_HITS  = krs_pkg::MAX_HITS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire krs_pkg::in_t                    s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output krs_pkg::out_t                        m_data,
    input  wire logic                            cfg_we,
    input  wire logic [krs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [krs_pkg::CFG_WIDTH-1:0]   cfg_data
);

    localparam int IW  = $clog2(MAX_NODES);
    localparam int SD  = krs_pkg::STACK_DEPTH;
    localparam int SPW = $clog2(SD + 1);
    localparam int HCW = $clog2(MAX_HITS + 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ADDR  = 6'b000010,
        ST_S1    = 6'b000100,
        ST_S2    = 6'b001000,
        ST_DEC   = 6'b010000,
        ST_FLUSH = 6'b100000
    } state_t;

    typedef struct packed {
        logic [1:0]    phase;
        logic [IW-1:0] idx;
    } entry_t;

    state_t             state_reg, state_next;
    logic [11:0]        node_count_reg;
    logic [47:0]        radius_reg;
    logic signed [32:0] facing_reg;
    krs_pkg::in_t       query_reg;
    logic [IW-1:0]      limit_reg;
    entry_t             stack_reg [SD];
    logic [SPW-1:0]     sp_reg;
    logic [HCW-1:0]     hit_count_reg;
    logic               trunc_reg;
    logic               pend_valid_reg;
    logic [IW-1:0]      pend_idx_reg;
    logic               m_valid_reg;
    krs_pkg::out_t      m_data_reg;

    krs_pkg::node_t     wr_node, rd_node;
    krs_pkg::eval_t     ev;
    entry_t             top;
    logic               wr_en, out_free, m_load;
    logic [IW:0]        cnt, child_lo;
    logic               interior, test_self, hit, keep_hit, stall;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign top      = stack_reg[SPW'(sp_reg - SPW'(1))];

    assign wr_node.px    = s_data.pos_x;
    assign wr_node.py    = s_data.pos_y;
    assign wr_node.pz    = s_data.pos_z;
    assign wr_node.nx    = s_data.nrm_x;
    assign wr_node.ny    = s_data.nrm_y;
    assign wr_node.nz    = s_data.nrm_z;
    assign wr_node.plane = s_data.split_axis;
    assign wr_en = s_valid && s_ready && (s_data.func == krs_pkg::FUNC_WRITE)
                   && (32'(s_data.node_index) < 32'(MAX_NODES));

    krs_ram #(
        .WIDTH ($bits(krs_pkg::node_t)),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (IW'(s_data.node_index)),
        .wr_data (wr_node),
        .rd_addr (top.idx),
        .rd_data (rd_node)
    );

    krs_eval u_eval (
        .aclk             (aclk),
        .node             (rd_node),
        .query            (query_reg),
        .radius_sq        (radius_reg),
        .facing_threshold (facing_reg),
        .res              (ev)
    );

    // clamp count to the store, interior bound is count/2 - 1
    always_comb begin
        if (32'(node_count_reg) > 32'(MAX_NODES - 1)) begin
            cnt = (IW+1)'(MAX_NODES - 1);
        end else begin
            cnt = (IW+1)'(node_count_reg);
        end
    end

    assign interior  = (top.idx < limit_reg);
    assign child_lo  = {top.idx, 1'b0};
    assign test_self = (top.phase == krs_pkg::PH_SELF)
                       || ((top.phase == krs_pkg::PH_DESCEND) && !interior)
                       || ((top.phase == krs_pkg::PH_FAR) && !ev.plane_in);
    assign hit      = test_self && ev.in_radius && ev.facing;
    assign keep_hit = hit && (32'(hit_count_reg) < 32'(MAX_HITS));
    assign stall    = keep_hit && pend_valid_reg && !out_free;
    assign m_load   = ((state_reg == ST_DEC) && !stall && keep_hit && pend_valid_reg)
                      || ((state_reg == ST_FLUSH) && out_free);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_data.func == krs_pkg::FUNC_QUERY) begin
                    state_next = (cnt == '0) ? ST_FLUSH : ST_ADDR;
                end
            end
            ST_ADDR:  state_next = ST_S1;
            ST_S1:    state_next = ST_S2;
            ST_S2:    state_next = ST_DEC;
            ST_DEC: begin
                if (!stall) begin
                    if (test_self && sp_reg == SPW'(1)) begin
                        state_next = ST_FLUSH;
                    end else begin
                        state_next = ST_ADDR;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            node_count_reg <= '0;
            radius_reg     <= '0;
            facing_reg     <= krs_pkg::FACING_RESET;
            sp_reg         <= '0;
            hit_count_reg  <= '0;
            trunc_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                case (cfg_index)
                    krs_pkg::CFG_NODE_COUNT: node_count_reg <= cfg_data[11:0];
                    krs_pkg::CFG_RADIUS_SQ:  radius_reg     <= cfg_data[47:0];
                    krs_pkg::CFG_FACING:     facing_reg     <= signed'(cfg_data[32:0]);
                    default: ;
                endcase
            end

            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_data.func == krs_pkg::FUNC_QUERY) begin
                        query_reg      <= s_data;
                        limit_reg      <= (cnt >= (IW+1)'(2))
                                          ? IW'((cnt >> 1) - (IW+1)'(1)) : '0;
                        hit_count_reg  <= '0;
                        trunc_reg      <= 1'b0;
                        pend_valid_reg <= 1'b0;
                        if (cnt != '0) begin
                            stack_reg[0] <= '{phase: krs_pkg::PH_DESCEND, idx: IW'(1)};
                            sp_reg       <= SPW'(1);
                        end else begin
                            sp_reg <= '0;
                        end
                    end
                end
                ST_DEC: begin
                    if (!stall) begin
                        if (test_self) begin
                            if (keep_hit) begin
                                if (pend_valid_reg) begin
                                    m_data_reg  <= '{hit_index: 12'(pend_idx_reg),
                                                     hit_valid: 1'b1, last: 1'b0,
                                                     truncated: 1'b0};
                                end
                                pend_valid_reg <= 1'b1;
                                pend_idx_reg   <= top.idx;
                                hit_count_reg  <= hit_count_reg + HCW'(1);
                            end else if (hit) begin
                                trunc_reg <= 1'b1;
                            end
                            sp_reg <= sp_reg - SPW'(1);
                        end else begin
                            // descend: near child first, then the far side
                            stack_reg[SPW'(sp_reg - SPW'(1))].phase <=
                                (top.phase == krs_pkg::PH_DESCEND)
                                ? krs_pkg::PH_FAR : krs_pkg::PH_SELF;
                            if (32'(sp_reg) < SD) begin
                                stack_reg[sp_reg].phase <= krs_pkg::PH_DESCEND;
                                stack_reg[sp_reg].idx   <=
                                    IW'(child_lo | (IW+1)'(
                                        (top.phase == krs_pkg::PH_DESCEND)
                                        == ev.plane_gt));
                                sp_reg <= sp_reg + SPW'(1);
                            end
                        end
                    end
                end
                ST_FLUSH: begin
                    if (out_free) begin
                        if (pend_valid_reg) begin
                            m_data_reg <= '{hit_index: 12'(pend_idx_reg), hit_valid: 1'b1,
                                            last: 1'b1, truncated: trunc_reg};
                        end else begin
                            m_data_reg <= '{hit_index: 12'd0, hit_valid: 1'b0,
                                            last: 1'b1, truncated: 1'b0};
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== src/krs_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module krs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== src/krs_eval.sv =====
// Node test datapath: differences, squares, dot product and compares.
`timescale 1ns / 1ps
`default_nettype none
module krs_eval (
    input  wire logic                 aclk,
    input  wire krs_pkg::node_t       node,
    input  wire krs_pkg::in_t         query,
    input  wire logic [47:0]          radius_sq,
    input  wire logic signed [32:0]   facing_threshold,
    output krs_pkg::eval_t            res
);

    localparam int DW = krs_pkg::COORD_BITS + 1;

    logic signed [DW-1:0] d_reg [3];
    logic signed [31:0]   prod_reg [3];
    logic [1:0]           ax_reg;

    logic [63:0]          sq_reg [3];
    logic [2:0]           sat_reg;
    logic                 gt_reg;
    logic [1:0]           ax2_reg;
    logic signed [33:0]   dot_reg;

    logic signed [DW-1:0] d_next [3];
    logic [DW-1:0]        mag [3];
    logic [63:0]          mag64 [3];
    logic [31:0]          mag32 [3];
    logic [65:0]          dist_sum;

    always_comb begin
        d_next[0] = DW'(query.pos_x) - DW'(node.px);
        d_next[1] = DW'(query.pos_y) - DW'(node.py);
        d_next[2] = DW'(query.pos_z) - DW'(node.pz);
        for (int i = 0; i < 3; i++) begin
            mag[i]   = d_reg[i][DW-1] ? DW'(-d_reg[i]) : DW'(d_reg[i]);
            mag64[i] = 64'(mag[i]);
            mag32[i] = mag64[i][31:0];
        end
    end

    // stage one: differences and normal products
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            d_reg[i] <= d_next[i];
        end
        prod_reg[0] <= query.nrm_x * node.nx;
        prod_reg[1] <= query.nrm_y * node.ny;
        prod_reg[2] <= query.nrm_z * node.nz;
        ax_reg      <= (node.plane == 2'd3) ? 2'd2 : node.plane;
    end

    // stage two: squares with saturation flags, dot sum
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            sq_reg[i]  <= 64'(mag32[i]) * 64'(mag32[i]);
            sat_reg[i] <= |mag64[i][63:32];
        end
        gt_reg  <= (d_reg[ax_reg] > 0);
        ax2_reg <= ax_reg;
        dot_reg <= 34'(prod_reg[0]) + 34'(prod_reg[1]) + 34'(prod_reg[2]);
    end

    assign dist_sum = 66'(sq_reg[0]) + 66'(sq_reg[1]) + 66'(sq_reg[2]);

    always_comb begin
        res.in_radius = !(|sat_reg) && (dist_sum < 66'(radius_sq));
        res.facing    = (35'(dot_reg) >= 35'(facing_threshold));
        res.plane_in  = !sat_reg[ax2_reg] && (sq_reg[ax2_reg] < 64'(radius_sq));
        res.plane_gt  = gt_reg;
    end

endmodule
`default_nettype wire

// ===== sim/tb_kd_tree_radius_search_top.sv =====
// Self-checking testbench for the kd-tree radius search block.
`timescale 1ns / 1ps
`default_nettype none
module tb_kd_tree_radius_search_top;

    localparam int CW = krs_pkg::COORD_BITS;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    krs_pkg::in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    krs_pkg::out_t m_data;
    logic cfg_we = 1'b0;
    logic [krs_pkg::CFG_IDX_W-1:0] cfg_index = krs_pkg::CFG_NODE_COUNT;
    logic [krs_pkg::CFG_WIDTH-1:0] cfg_data = '0;

    kd_tree_radius_search_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    localparam longint FACING_LO = -64'sd3221225472;
    localparam longint FACING_HI = 64'sd3221225472;
    localparam longint unsigned RADIUS_MAX = 64'hFFFF_FFFF_FFFF;

    // mirrored block state
    logic [11:0] tree_size = 12'd0;
    longint unsigned search_rsq = 0;
    longint facing_min = longint'(krs_pkg::FACING_RESET);
    logic signed [CW-1:0] tree_px [krs_pkg::MAX_NODES];
    logic signed [CW-1:0] tree_py [krs_pkg::MAX_NODES];
    logic signed [CW-1:0] tree_pz [krs_pkg::MAX_NODES];
    logic signed [15:0] tree_nx [krs_pkg::MAX_NODES];
    logic signed [15:0] tree_ny [krs_pkg::MAX_NODES];
    logic signed [15:0] tree_nz [krs_pkg::MAX_NODES];
    logic [1:0] tree_axis [krs_pkg::MAX_NODES];

    longint qpos [3];
    longint qnrm [3];
    longint unsigned interior_lim;
    bit hits_dropped;

    krs_pkg::in_t pending_items[$];
    krs_pkg::out_t expected_hits[$];
    krs_pkg::out_t walk_hits[$];
    int errors = 0;
    bit hold_sender = 1'b0;
    bit no_idle = 1'b0;

    function automatic longint unsigned dist_term(longint d);
        longint unsigned a;
        a = (d < 0) ? longint'(-d) : longint'(d);
        if (a > 64'hFFFF_FFFF) return '1;
        return a * a;
    endfunction

    function automatic longint node_coord(int unsigned idx, int unsigned ax);
        if (ax == 0) return longint'(tree_px[idx]);
        if (ax == 1) return longint'(tree_py[idx]);
        return longint'(tree_pz[idx]);
    endfunction

    function automatic void walk_node(int unsigned idx);
        int unsigned ax;
        longint d;
        longint unsigned dist_sq;
        longint dot;
        krs_pkg::out_t hit;
        ax = (tree_axis[idx] > 2) ? 2 : tree_axis[idx];
        d = qpos[ax] - node_coord(idx, ax);
        if (idx < interior_lim) begin
            walk_node((d > 0) ? 2 * idx + 1 : 2 * idx);
            if (dist_term(d) < search_rsq)
                walk_node((d > 0) ? 2 * idx : 2 * idx + 1);
        end
        dist_sq = dist_term(qpos[0] - longint'(tree_px[idx]))
                + dist_term(qpos[1] - longint'(tree_py[idx]))
                + dist_term(qpos[2] - longint'(tree_pz[idx]));
        dot = qnrm[0] * longint'(tree_nx[idx]) + qnrm[1] * longint'(tree_ny[idx])
            + qnrm[2] * longint'(tree_nz[idx]);
        if (dist_sq < search_rsq && dot >= facing_min) begin
            hit = '0;
            hit.hit_index = idx[11:0];
            hit.hit_valid = 1'b1;
            walk_hits.insert(walk_hits.size(), hit);
        end
    endfunction

    // update the mirror on a write, or queue the hits a query produces
    function automatic void predict_search(krs_pkg::in_t it);
        krs_pkg::out_t tail;
        if (it.func == krs_pkg::FUNC_WRITE) begin
            tree_px[it.node_index] = it.pos_x;
            tree_py[it.node_index] = it.pos_y;
            tree_pz[it.node_index] = it.pos_z;
            tree_nx[it.node_index] = it.nrm_x;
            tree_ny[it.node_index] = it.nrm_y;
            tree_nz[it.node_index] = it.nrm_z;
            tree_axis[it.node_index] = it.split_axis;
            return;
        end
        qpos[0] = longint'(it.pos_x);
        qpos[1] = longint'(it.pos_y);
        qpos[2] = longint'(it.pos_z);
        qnrm[0] = longint'(it.nrm_x);
        qnrm[1] = longint'(it.nrm_y);
        qnrm[2] = longint'(it.nrm_z);
        interior_lim = (tree_size >= 2) ? tree_size / 2 - 1 : 0;
        walk_hits.delete();
        if (tree_size >= 1) walk_node(1);
        if (walk_hits.size() == 0) begin
            tail = '0;
            tail.last = 1'b1;
            expected_hits.insert(expected_hits.size(), tail);
            return;
        end
        // cut the walk's hits down to the cap, flag any that were dropped
        hits_dropped = walk_hits.size() > krs_pkg::MAX_HITS;
        while (walk_hits.size() > krs_pkg::MAX_HITS) void'(walk_hits.pop_back());
        walk_hits[walk_hits.size() - 1].last = 1'b1;
        walk_hits[walk_hits.size() - 1].truncated = hits_dropped;
        foreach (walk_hits[i]) expected_hits.insert(expected_hits.size(), walk_hits[i]);
    endfunction

    task automatic report_mismatch(string what, krs_pkg::out_t got, krs_pkg::out_t want);
        errors++;
        $display("[%0t] %s: got idx %0d v%0d l%0d t%0d, want idx %0d v%0d l%0d t%0d",
                 $time, what, got.hit_index, got.hit_valid, got.last, got.truncated,
                 want.hit_index, want.hit_valid, want.last, want.truncated);
    endtask

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // sender
    int send_gap = 0;
    always @(posedge aclk) begin
        logic next_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                predict_search(s_data);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_items.size() > 0 && !hold_sender) begin
                    s_data <= pending_items.pop_front();
                    next_valid = 1'b1;
                    send_gap = pick_gap();
                end
            end
            s_valid <= next_valid;
        end
    end

    // receiver
    int recv_gap = 0;
    always @(posedge aclk) begin
        krs_pkg::out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_hits.size() == 0) begin
                    report_mismatch("unexpected result", m_data, '0);
                end else begin
                    want = expected_hits.pop_front();
                    if (m_data.hit_index != want.hit_index ||
                        m_data.hit_valid != want.hit_valid ||
                        m_data.last != want.last || m_data.truncated != want.truncated)
                        report_mismatch("result mismatch", m_data, want);
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                recv_gap = pick_gap();
            end
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_valid || expected_hits.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [krs_pkg::CFG_IDX_W-1:0] idx, longint val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[krs_pkg::CFG_WIDTH-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == krs_pkg::CFG_NODE_COUNT) tree_size = val[11:0];
        else if (idx == krs_pkg::CFG_RADIUS_SQ) search_rsq = val[47:0];
        else facing_min = longint'(signed'(val[32:0]));
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        int unsigned r;
        r = $urandom;
        if ($urandom_range(0, 4) == 0) return CW'(r);
        return CW'($signed($urandom_range(0, 2 ** 19)) - 2 ** 18);
    endfunction

    function automatic krs_pkg::in_t make_item(logic func, logic [11:0] idx);
        krs_pkg::in_t it;
        it.func = func;
        it.node_index = idx;
        it.pos_x = rand_coord();
        it.pos_y = rand_coord();
        it.pos_z = rand_coord();
        it.nrm_x = 16'($urandom);
        it.nrm_y = 16'($urandom);
        it.nrm_z = 16'($urandom);
        it.split_axis = 2'($urandom_range(0, 3));
        return it;
    endfunction

    // set up the registers, optionally fill nodes 1..n, then queue queries
    // mixed with node rewrites
    task automatic run_phase(int n, longint unsigned rsq, longint fac, int queries,
                             bit fill);
        krs_pkg::in_t it;
        wait_drained();
        write_reg(krs_pkg::CFG_NODE_COUNT, n);
        write_reg(krs_pkg::CFG_RADIUS_SQ, longint'(rsq));
        write_reg(krs_pkg::CFG_FACING, fac);
        if (fill) begin
            for (int i = 1; i <= n; i++)
                pending_items.insert(pending_items.size(),
                                     make_item(krs_pkg::FUNC_WRITE, 12'(i)));
        end
        for (int i = 0; i < queries; i++) begin
            if (n > 0 && $urandom_range(0, 5) == 0)
                pending_items.insert(pending_items.size(),
                                     make_item(krs_pkg::FUNC_WRITE,
                                               12'($urandom_range(1, n))));
            it = make_item(krs_pkg::FUNC_QUERY, 12'($urandom));
            pending_items.insert(pending_items.size(), it);
        end
    endtask

    initial begin
        krs_pkg::in_t it;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // empty tree under reset settings
        pending_items.insert(pending_items.size(),
                             make_item(krs_pkg::FUNC_QUERY, 12'd0));
        run_phase(0, RADIUS_MAX, FACING_LO, 2, 1'b1);
        run_phase(1, RADIUS_MAX, FACING_LO, 2, 1'b1);
        run_phase(3, RADIUS_MAX, FACING_LO, 2, 1'b1);

        // extreme corners, axis three, the facing limit met exactly
        wait_drained();
        write_reg(krs_pkg::CFG_NODE_COUNT, 7);
        write_reg(krs_pkg::CFG_FACING, FACING_HI);
        for (int i = 0; i <= 7; i++) begin
            it = make_item(krs_pkg::FUNC_WRITE, 12'(i));
            it.pos_x = (i & 1) ? 24'sh7FFFFF : -24'sh800000;
            it.pos_y = (i & 2) ? 24'sh7FFFFF : -24'sh800000;
            it.pos_z = (i & 4) ? 24'sh7FFFFF : -24'sh800000;
            it.nrm_x = -16'sh8000;
            it.nrm_y = -16'sh8000;
            it.nrm_z = (i == 5) ? 16'sh7FFF : -16'sh8000;
            it.split_axis = 2'(i % 4);
            pending_items.insert(pending_items.size(), it);
        end
        for (int i = 0; i < 4; i++) begin
            it = make_item(krs_pkg::FUNC_QUERY, 12'hFFF);
            it.pos_x = (i & 1) ? 24'sh7FFFFF : -24'sh800000;
            it.pos_y = (i & 2) ? 24'sh7FFFFF : -24'sh800000;
            it.pos_z = 24'sh7FFFFF;
            it.nrm_x = -16'sh8000;
            it.nrm_y = -16'sh8000;
            it.nrm_z = -16'sh8000;
            pending_items.insert(pending_items.size(), it);
        end

        // nearly every node is a hit: overflows the hit cap
        run_phase(85, RADIUS_MAX, FACING_LO, 2, 1'b1);
        // hold off the sender until every hit so far is in
        while (pending_items.size() > 2) @(posedge aclk);
        hold_sender = 1'b1;
        while (expected_hits.size() > 0 || s_valid) @(posedge aclk);
        hold_sender = 1'b0;
        run_phase(85, 64'd1 << 34, longint'(krs_pkg::FACING_RESET), 5, 1'b0);
        run_phase(85, 0, FACING_LO, 1, 1'b0);
        no_idle = 1'b1;
        run_phase(85, 64'd1 << 36, 0, 4, 1'b0);
        wait_drained();
        no_idle = 1'b0;
        run_phase(7, 64'd1 << 35, -64'sd1, 5, 1'b1);

        wait_drained();
        repeat (50) @(posedge aclk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire
